/* design/ise_pkg.sv */
// ----------------------------------------------------------------------------
// ise_pkg
// Shared constants and types for the insertion sort engine.
// ----------------------------------------------------------------------------
package ise_pkg;

    localparam int DEPTH  = 16;   // capacity of the cell chain, 2..64
    localparam int DATA_W = 32;

    // What one cell shows its neighbors
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     valid;
        logic                     gt;     // valid and holds a value above the insert value
    } link_t;

    // Control broadcast to every cell
    typedef struct packed {
        logic insert;   // place the broadcast value, larger entries move up
        logic shift;    // drain: every entry moves one place toward cell 0
    } cell_ctrl_t;

endpackage

/* design/insertion_sort_engine.sv */
// ----------------------------------------------------------------------------
// insertion_sort_engine
// Streaming insertion sorter for signed 32-bit values on a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, value, last) takes one element per
//   transfer. While loading, in_ready is high and one element is taken every
//   cycle: each element is compared against all cells at once and inserted
//   into the chain, larger entries moving up one cell. Equal values keep
//   arrival order. Once DEPTH elements are held, further elements of the
//   set are dropped and the set is flagged.
//   The element marked last is inserted unless the chain is full, then the
//   engine drains: cell 0 is the output (sorted_value, last_out, overflow),
//   and each output transfer moves the whole chain one cell down. A set drains
//   in one output transfer per element held; in_ready is low during the drain.
//   First result appears the cycle after the last element's transfer.
//   Loading and draining do not overlap: no new element is taken until the
//   set has drained through the single output port at cell 0.
//   A stalled receiver simply holds the chain; nothing is lost.
//   Reset clears all valid bits, the drop flag and returns to loading.
// ----------------------------------------------------------------------------
module insertion_sort_engine
    import ise_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // input channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     last,
    // output channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     last_out,
    output logic                     overflow
);

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    state_t     state_reg, state_next;
    logic       dropped_reg, dropped_next;
    logic       in_xfer, out_xfer, full;
    cell_ctrl_t ctrl;
    link_t      cell_link [DEPTH];

    assign in_ready  = (state_reg == ST_LOAD);
    assign in_xfer   = in_valid && in_ready;
    assign full      = cell_link[DEPTH-1].valid;

    // cell 0 is the head of the sorted set
    assign out_valid    = (state_reg == ST_DRAIN) && cell_link[0].valid;
    assign out_xfer     = out_valid && out_ready;
    assign sorted_value = cell_link[0].value;
    assign last_out     = !cell_link[1].valid;
    assign overflow     = dropped_reg;

    assign ctrl.insert = in_xfer && !full;
    assign ctrl.shift  = out_xfer;

    // ---- the chain ----
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            link_t lo_link, hi_link;

            if (i == 0)
            begin : g_first
                // below cell 0: always occupied, never larger
                assign lo_link.value = '0;
                assign lo_link.valid = 1'b1;
                assign lo_link.gt    = 1'b0;
            end
            else
            begin : g_lo
                assign lo_link = cell_link[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                // above the top cell: empty
                assign hi_link.value = '0;
                assign hi_link.valid = 1'b0;
                assign hi_link.gt    = 1'b0;
            end
            else
            begin : g_hi
                assign hi_link = cell_link[i+1];
            end

            ise_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .ins_value (value),
                .lo        (lo_link),
                .hi        (hi_link),
                .link      (cell_link[i])
            );
        end
    endgenerate

    // ---- sequencing ----
    always_comb
    begin
        state_next   = state_reg;
        dropped_next = dropped_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    if (last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                // final transfer of the set empties the chain
                if (out_xfer && last_out)
                begin
                    state_next   = ST_LOAD;
                    dropped_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            dropped_reg <= dropped_next;
        end
    end

endmodule

/* design/ise_cell.sv */
// ----------------------------------------------------------------------------
// ise_cell
// One place of the sorted chain: holds one value and its valid bit.
// ----------------------------------------------------------------------------
module ise_cell
    import ise_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctrl_t               ctrl,
    input  logic signed [DATA_W-1:0] ins_value,
    input  link_t                    lo,      // neighbor one place lower
    input  link_t                    hi,      // neighbor one place higher
    output link_t                    link
);

    logic signed [DATA_W-1:0] value_reg, value_next;
    logic                     valid_reg, valid_next;
    logic                     gt;

    assign gt = valid_reg && (value_reg > ins_value);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.insert)
        begin
            if (lo.gt)
            begin
                // lower neighbor is larger too: it moves up into this place
                value_next = lo.value;
                valid_next = 1'b1;
            end
            else if (gt || (!valid_reg && lo.valid))
            begin
                // insertion point: first larger entry or first free place
                value_next = ins_value;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.shift)
        begin
            value_next = hi.value;
            valid_next = hi.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.value = value_reg;
    assign link.valid = valid_reg;
    assign link.gt    = gt;

endmodule
